### hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// shared types, opcodes and saturation helpers for the q24.8 fixed-point alu
// ----------------------------------------------------------------------------
package fpa_pkg;

   // opcodes carried on the request tuser field
   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_GE       = 4'd6,
      OP_LE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_INC      = 4'd10,
      OP_DEC      = 4'd11,
      OP_MIN      = 4'd12,
      OP_MAX      = 4'd13,
      OP_TO_INT   = 4'd14,
      OP_FROM_INT = 4'd15
   } op_type;

   localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   // classified request as it sits in the queue
   typedef struct packed {
      op_type      op;
      logic [31:0] a;
      logic [31:0] b;
      logic        b_zero;
   } item_type;

   // one result transaction
   typedef struct packed {
      logic [31:0] value;
      logic        cmp;
      logic        ovf;
      logic        dz;
   } result_type;

   typedef struct packed {
      logic [31:0] value;
      logic        ovf;
   } sat_type;

   // clamp a sign-magnitude value to the signed 32-bit range
   function automatic sat_type sat_mag(input logic [63:0] m, input logic neg);
      sat_type s;
      s.ovf   = 1'b0;
      s.value = '0;
      if (neg) begin
         if (m > 64'h0000_0000_8000_0000) begin
            s.ovf   = 1'b1;
            s.value = SAT_MIN;
         end else begin
            s.value = 32'(64'd0 - m);
         end
      end else begin
         if (m > 64'h0000_0000_7fff_ffff) begin
            s.ovf   = 1'b1;
            s.value = SAT_MAX;
         end else begin
            s.value = m[31:0];
         end
      end
      return s;
   endfunction

   // clamp a 33-bit two's complement sum to 32 bits
   function automatic sat_type sat33(input logic [32:0] v);
      sat_type s;
      s.ovf   = v[32] ^ v[31];
      s.value = s.ovf ? (v[32] ? SAT_MIN : SAT_MAX) : v[31:0];
      return s;
   endfunction

endpackage

### hw/rtl/fixed_point_q24_8_alu_core.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core
// signed 32-bit fixed-point alu with saturation and rounding
// ----------------------------------------------------------------------------
// usage:
//   req channel: one transaction per operation; tuser[3:0] holds the opcode,
//   tdata holds operand_a in [31:0] and operand_b in [63:32].
//   rsp channel: one transaction per request, in request order.
//   a new request is taken every cycle while the response side keeps up, so
//   throughput is one operation per cycle.
//   all opcodes travel the same pipeline, whose depth is set by the divider,
//   which resolves one quotient bit per stage over 33 + FRAC_BITS stages.
//   a two-entry queue separates the input stage from the execution pipeline.
//   when rsp_tready is low with a result held, the whole execution pipeline
//   freezes, the queue fills, and req_tready drops once the input stage is full.
//   reset (synchronous, active high) empties the pipeline and queue; no
//   operation state survives, since the block is stateless.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_core #(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // operand_a[31:0], operand_b[63:32]
   input  logic [7:0]  req_tuser,  // kind[3:0], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // result_value[31:0], compare_true[32],
                                   // overflowed[33], divided_by_zero[34], pad
);
   import fpa_pkg::*;

   logic     push, full, pop, empty;
   item_type push_item, head;

   fpa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_item  (push_item),
      .queue_full (full)
   );

   fpa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (empty),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

### hw/rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// accepts request transactions, decodes the opcode and pushes into the queue
// ----------------------------------------------------------------------------
module fpa_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [63:0]      req_tdata,
   input  logic [7:0]       req_tuser,
   output logic             push,
   output fpa_pkg::item_type push_item,
   input  logic             queue_full
);
   import fpa_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   // input slot frees whenever its content moves on
   assign push       = valid_ff && !queue_full;
   assign req_tready = !valid_ff || push;
   assign take       = req_tvalid && req_tready;
   assign push_item  = item_ff;

   // classify the incoming transaction
   always_comb begin
      item_in.op     = op_type'(req_tuser[3:0]);
      item_in.a      = req_tdata[31:0];
      item_in.b      = req_tdata[63:32];
      item_in.b_zero = (req_tdata[63:32] == 32'd0);
      valid_in       = take || (valid_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

### hw/rtl/fpa_queue.sv
// ----------------------------------------------------------------------------
// fpa_queue
// two-entry queue between the front and the execution pipeline
// ----------------------------------------------------------------------------
module fpa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fpa_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output fpa_pkg::item_type head
);
   import fpa_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // fill count stays within the two entries
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");

endmodule

### hw/rtl/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module fpa_div #(
   parameter int NUM_W = 41
) (
   input  logic             clock,
   input  logic             advance,
   input  logic [NUM_W-1:0] num,
   input  logic [31:0]      den,
   output logic [NUM_W-1:0] quot
);
   import fpa_pkg::*;

   logic [NUM_W-1:0] num_ff [NUM_W+1];
   logic [31:0]      rem_ff [NUM_W+1];
   logic [31:0]      den_ff [NUM_W+1];

   // stage zero is the operand entry point
   always_comb begin
      num_ff[0] = num;
      rem_ff[0] = '0;
      den_ff[0] = den;
   end

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [32:0]      trial;
      logic             ge;
      logic [31:0]      rem_in;
      logic [NUM_W-1:0] num_in;

      // shift in one dividend bit and try the subtract
      always_comb begin
         trial  = {rem_ff[k], num_ff[k][NUM_W-1]};
         ge     = (trial >= {1'b0, den_ff[k]});
         rem_in = ge ? 32'(trial - {1'b0, den_ff[k]}) : trial[31:0];
         num_in = {num_ff[k][NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1] <= rem_in;
            num_ff[k+1] <= num_in;
            den_ff[k+1] <= den_ff[k];
         end
      end
   end

   assign quot = num_ff[NUM_W];

endmodule

### hw/rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// execution pipeline: simple ops, multiplier, divider and result register
// ----------------------------------------------------------------------------
module fpa_back #(
   parameter int FRAC_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  fpa_pkg::item_type head,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata
);
   import fpa_pkg::*;

   localparam int NUM_W = 32 + FRAC_BITS + 1;
   localparam logic [32:0] ONE = 33'd1 << FRAC_BITS;
   localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

   typedef struct packed {
      logic       is_div;
      logic       is_mul;
      logic       neg;
      result_type res;
   } side_type;

   logic advance;

   // entry stage registers
   logic             e_valid_ff;
   side_type         e_side_ff, e_side_in;
   logic [63:0]      prod_ff, prod_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [31:0]      den_ff, den_in;

   // sideband line running beside the divider
   logic     s_valid_ff [NUM_W];
   side_type s_side_ff  [NUM_W];
   side_type s1_side_in;

   logic             rsp_valid_ff;
   result_type       rsp_ff, rsp_in;
   logic [NUM_W-1:0] quot;

   // whole pipeline moves when the result slot can take a transaction
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign pop        = advance && !queue_empty;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.dz, rsp_ff.ovf, rsp_ff.cmp, rsp_ff.value};

   // simple operations and operand preparation
   always_comb begin
      logic signed [31:0] sa, sb;
      logic [32:0]        ax;
      logic [32:0]        bx;
      logic [32+FRAC_BITS-1:0] shl;
      logic [31:0]        mag_a, mag_b;
      sat_type            s;
      sa = head.a;
      sb = head.b;
      ax = {head.a[31], head.a};
      bx = {head.b[31], head.b};
      shl = {head.a, FRAC_BITS'(0)};
      mag_a = head.a[31] ? 32'(32'd0 - head.a) : head.a;
      mag_b = head.b[31] ? 32'(32'd0 - head.b) : head.b;
      s = '0;
      e_side_in        = '0;
      e_side_in.is_div = (head.op == OP_DIV);
      e_side_in.is_mul = (head.op == OP_MUL);
      e_side_in.neg    = head.a[31] ^ head.b[31];
      unique case (head.op)
         OP_ADD: s = sat33(ax + bx);
         OP_SUB: s = sat33(ax - bx);
         OP_INC: s = sat33(ax + ONE);
         OP_DEC: s = sat33(ax - ONE);
         OP_GT:  e_side_in.res.cmp = (sa > sb);
         OP_LT:  e_side_in.res.cmp = (sa < sb);
         OP_GE:  e_side_in.res.cmp = (sa >= sb);
         OP_LE:  e_side_in.res.cmp = (sa <= sb);
         OP_EQ:  e_side_in.res.cmp = (sa == sb);
         OP_NE:  e_side_in.res.cmp = (sa != sb);
         OP_MIN: s.value = (sa < sb) ? head.a : head.b;
         OP_MAX: s.value = (sa > sb) ? head.a : head.b;
         OP_TO_INT: s.value = 32'(sa >>> FRAC_BITS);
         OP_FROM_INT: begin
            s.ovf   = !((&shl[32+FRAC_BITS-1:31]) || !(|shl[32+FRAC_BITS-1:31]));
            s.value = s.ovf ? (head.a[31] ? SAT_MIN : SAT_MAX) : shl[31:0];
         end
         OP_DIV: begin
            e_side_in.res.dz = head.b_zero;
            s.value = head.a[31] ? SAT_MIN : SAT_MAX;
         end
         default: s = '0;
      endcase
      e_side_in.res.value = s.value;
      e_side_in.res.ovf   = s.ovf;
      prod_in = 64'(sa * sb);
      num_in  = {mag_a, (FRAC_BITS + 1)'(0)};
      den_in  = head.b_zero ? 32'd1 : mag_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff <= !queue_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_side_ff <= e_side_in;
         prod_ff   <= prod_in;
         num_ff    <= num_in;
         den_ff    <= den_in;
      end
   end

   fpa_div #(.NUM_W(NUM_W)) u_div (
      .clock   (clock),
      .advance (advance),
      .num     (num_ff),
      .den     (den_ff),
      .quot    (quot)
   );

   // multiply rounding: nearest, ties away from zero
   always_comb begin
      logic [63:0] magp;
      logic [63:0] m;
      sat_type     s;
      magp = prod_ff[63] ? 64'd0 - prod_ff : prod_ff;
      m    = (magp + HALF) >> FRAC_BITS;
      s    = sat_mag(m, prod_ff[63]);
      s1_side_in = e_side_ff;
      if (e_side_ff.is_mul) begin
         s1_side_in.res.value = s.value;
         s1_side_in.res.ovf   = s.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_W; i++) begin
            s_valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         s_valid_ff[0] <= e_valid_ff;
         for (int i = 1; i < NUM_W; i++) begin
            s_valid_ff[i] <= s_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_side_ff[0] <= s1_side_in;
         for (int i = 1; i < NUM_W; i++) begin
            s_side_ff[i] <= s_side_ff[i-1];
         end
      end
   end

   // divide rounding from the doubled quotient, then result select
   always_comb begin
      logic [NUM_W:0] m;
      sat_type        s;
      m = ({1'b0, quot} + (NUM_W + 1)'(1)) >> 1;
      s = sat_mag(64'(m), s_side_ff[NUM_W-1].neg);
      rsp_in = s_side_ff[NUM_W-1].res;
      if (s_side_ff[NUM_W-1].is_div && !s_side_ff[NUM_W-1].res.dz) begin
         rsp_in.value = s.value;
         rsp_in.ovf   = s.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s_valid_ff[NUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.dz && rsp_ff.ovf))
      else $error("divide by zero and overflow both set");
   a_cmp_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.cmp |-> rsp_ff.value == 32'd0)
      else $error("comparison result carries a value");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(e_valid_ff) && $stable(s_valid_ff[NUM_W-1]))
      else $error("pipeline moved while stalled");

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stream testbench for the q24.8 fixed-point alu: a directed table of edge
// cases, then random operations, each checked field by field against its table
// entry or an exact-arithmetic predictor, under random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fpa_pkg::*;

   localparam int FRAC      = 8;
   localparam int LATENCY   = FRAC + 36;
   localparam int N_RANDOM  = 1700;
   localparam int WATCHDOG  = 5000;
   localparam int HOLD_LONG = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [7:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   // one operation of the stimulus
   typedef struct {
      op_type      op;
      logic [31:0] a;
      logic [31:0] b;
      bit          known;  // expected result typed into the table
      result_type  res;
   } op_row_type;

   result_type  alu_expected_q[$];
   int          n_errors = 0;
   int          idle_cycles = 0;
   bit          sending_done = 1'b0;
   bit          hold_request = 1'b0;
   int          sent_count = 0;

   fixed_point_q24_8_alu_core #(.FRAC_BITS(FRAC)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // magnitude of a signed 64-bit value
   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // saturate an exact signed value to 32 bits
   function automatic result_type clamp_value(input logic signed [63:0] v);
      result_type r;
      r = '0;
      if (v > 64'sd2147483647) begin
         r.value = SAT_MAX;
         r.ovf   = 1'b1;
      end else if (v < -64'sd2147483648) begin
         r.value = SAT_MIN;
         r.ovf   = 1'b1;
      end else begin
         r.value = v[31:0];
      end
      return r;
   endfunction

   // exact result of one alu operation
   function automatic result_type alu_predict(input op_type op, input logic [31:0] ra,
                                              input logic [31:0] rb);
      logic signed [63:0] a, b, p, one;
      logic [63:0]        m, n, d;
      result_type         r;
      a   = 64'(signed'(ra));
      b   = 64'(signed'(rb));
      one = 64'sd1 <<< FRAC;
      r   = '0;
      case (op)
         OP_ADD: r = clamp_value(a + b);
         OP_SUB: r = clamp_value(a - b);
         OP_MUL: begin
            p = a * b;
            m = (magnitude(p) + (64'd1 << (FRAC - 1))) >> FRAC;
            r = clamp_value(p < 0 ? -$signed(m) : $signed(m));
         end
         OP_DIV: begin
            if (b == 0) begin
               r.dz    = 1'b1;
               r.value = a < 0 ? SAT_MIN : SAT_MAX;
            end else begin
               n = magnitude(a) << FRAC;
               d = magnitude(b);
               m = (2 * n + d) / (2 * d);
               r = clamp_value(((a < 0) != (b < 0)) ? -$signed(m) : $signed(m));
            end
         end
         OP_GT:  r.cmp = a > b;
         OP_LT:  r.cmp = a < b;
         OP_GE:  r.cmp = a >= b;
         OP_LE:  r.cmp = a <= b;
         OP_EQ:  r.cmp = a == b;
         OP_NE:  r.cmp = a != b;
         OP_INC: r = clamp_value(a + one);
         OP_DEC: r = clamp_value(a - one);
         OP_MIN: r.value = a < b ? ra : rb;
         OP_MAX: r.value = a > b ? ra : rb;
         OP_TO_INT: r.value = 32'(a >>> FRAC);
         default: r = clamp_value(a * one);
      endcase
      return r;
   endfunction

   function automatic result_type mk(input logic [31:0] v, input bit c, input bit o,
                                     input bit z);
      result_type r;
      r.value = v; r.cmp = c; r.ovf = o; r.dz = z;
      return r;
   endfunction

   function automatic op_row_type row(input op_type op, input logic [31:0] a,
                                      input logic [31:0] b, input bit known,
                                      input result_type res);
      op_row_type t;
      t.op = op; t.a = a; t.b = b; t.known = known; t.res = res;
      return t;
   endfunction

   // random operand, biased toward extremes and small values
   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return SAT_MAX - $urandom_range(0, 3);
         1: return SAT_MIN + $urandom_range(0, 3);
         2: return 32'($urandom_range(0, 1024)) - 32'd512;
         3: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // present one transaction and wait for its acceptance
   task automatic send_op(input op_type op, input logic [31:0] a, input logic [31:0] b,
                          input bit known, input result_type res);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tuser  <= {4'd0, op};
      do @(posedge clock); while (!req_tready);
      alu_expected_q.push_back(known ? res : alu_predict(op, a, b));
      sent_count++;
   endtask

   // stimulus
   initial begin
      op_row_type  tbl[$];
      op_type      op;
      logic [31:0] a, b;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tbl.push_back(row(OP_ADD, SAT_MAX, 32'd1, 1, mk(SAT_MAX, 0, 1, 0)));
      tbl.push_back(row(OP_ADD, SAT_MIN, SAT_MIN, 1, mk(SAT_MIN, 0, 1, 0)));
      tbl.push_back(row(OP_SUB, SAT_MIN, 32'd1, 1, mk(SAT_MIN, 0, 1, 0)));
      tbl.push_back(row(OP_SUB, 32'd0, SAT_MIN, 1, mk(SAT_MAX, 0, 1, 0)));
      tbl.push_back(row(OP_MUL, 32'h0000_0180, 32'h0000_0100, 1, mk(32'h180, 0, 0, 0)));
      tbl.push_back(row(OP_MUL, 32'd1, 32'h0000_0080, 0, '0));   // tie rounds away
      tbl.push_back(row(OP_MUL, 32'hffff_ffff, 32'h0000_0080, 0, '0));
      tbl.push_back(row(OP_MUL, SAT_MIN, SAT_MIN, 1, mk(SAT_MAX, 0, 1, 0)));
      tbl.push_back(row(OP_MUL, SAT_MAX, SAT_MIN, 1, mk(SAT_MIN, 0, 1, 0)));
      tbl.push_back(row(OP_DIV, 32'd5, 32'd0, 1, mk(SAT_MAX, 0, 0, 1)));
      tbl.push_back(row(OP_DIV, 32'd0, 32'd0, 1, mk(SAT_MAX, 0, 0, 1)));
      tbl.push_back(row(OP_DIV, 32'hffff_ffff, 32'd0, 1, mk(SAT_MIN, 0, 0, 1)));
      tbl.push_back(row(OP_DIV, SAT_MIN, 32'd1, 1, mk(SAT_MIN, 0, 1, 0)));
      tbl.push_back(row(OP_DIV, SAT_MIN, 32'hffff_ffff, 1, mk(SAT_MAX, 0, 1, 0)));
      tbl.push_back(row(OP_DIV, 32'd1, 32'd3, 0, '0));
      tbl.push_back(row(OP_GT, SAT_MAX, SAT_MIN, 1, mk(0, 1, 0, 0)));
      tbl.push_back(row(OP_LT, SAT_MAX, SAT_MIN, 1, mk(0, 0, 0, 0)));
      tbl.push_back(row(OP_GE, 32'd7, 32'd7, 1, mk(0, 1, 0, 0)));
      tbl.push_back(row(OP_LE, SAT_MIN, SAT_MIN, 1, mk(0, 1, 0, 0)));
      tbl.push_back(row(OP_EQ, 32'd7, 32'd7, 1, mk(0, 1, 0, 0)));
      tbl.push_back(row(OP_NE, 32'd7, 32'd7, 1, mk(0, 0, 0, 0)));
      tbl.push_back(row(OP_INC, SAT_MAX, 32'd0, 1, mk(SAT_MAX, 0, 1, 0)));
      tbl.push_back(row(OP_DEC, SAT_MIN, 32'hffff_ffff, 1, mk(SAT_MIN, 0, 1, 0)));
      tbl.push_back(row(OP_MIN, SAT_MIN, SAT_MAX, 1, mk(SAT_MIN, 0, 0, 0)));
      tbl.push_back(row(OP_MAX, 32'd9, 32'd9, 1, mk(32'd9, 0, 0, 0)));
      tbl.push_back(row(OP_TO_INT, 32'hffff_ff01, 32'd0, 1, mk(32'hffff_ffff, 0, 0, 0)));
      tbl.push_back(row(OP_FROM_INT, 32'h0080_0000, 32'd0, 1, mk(SAT_MAX, 0, 1, 0)));
      tbl.push_back(row(OP_FROM_INT, 32'hffff_fffe, 32'd0, 1,
                        mk(32'hffff_fe00, 0, 0, 0)));

      foreach (tbl[i]) send_op(tbl[i].op, tbl[i].a, tbl[i].b, tbl[i].known, tbl[i].res);

      // pause until the pipeline has drained completely
      req_tvalid <= 1'b0;
      wait (alu_expected_q.size() == 0);

      for (int i = 0; i < N_RANDOM; i++) begin
         // long receiver hold while the sender keeps offering transactions
         if (i == 200) hold_request = 1'b1;
         if (i == 900) begin
            req_tvalid <= 1'b0;
            wait (alu_expected_q.size() == 0);
         end
         op = op_type'($urandom_range(0, 15));
         a  = rand_operand();
         b  = $urandom_range(0, 9) == 0 ? a : rand_operand();
         if (op == OP_DIV && $urandom_range(0, 9) == 0) b = '0;
         send_op(op, a, b, 0, '0);
      end
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_LONG) @(posedge clock);
         end
         stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value = rsp_tdata[31:0];
         got.cmp   = rsp_tdata[32];
         got.ovf   = rsp_tdata[33];
         got.dz    = rsp_tdata[34];
         if (alu_expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            n_errors++;
         end else begin
            want = alu_expected_q.pop_front();
            if (got.value !== want.value || got.cmp !== want.cmp ||
                got.ovf !== want.ovf || got.dz !== want.dz) begin
               $display("%0t: mismatch expected value=%h cmp=%b ovf=%b dz=%b",
                        $time, want.value, want.cmp, want.ovf, want.dz);
               $display("%0t:          actual   value=%h cmp=%b ovf=%b dz=%b",
                        $time, got.value, got.cmp, got.ovf, got.dz);
               n_errors++;
            end
         end
      end
   end

   // watchdog on cycles with no accepted transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // end of run
   initial begin
      fork
         begin
            wait (sending_done && alu_expected_q.size() == 0);
            repeat (LATENCY * 2) @(posedge clock);
            if (n_errors == 0 && alu_expected_q.size() == 0)
               $display("end of test: clean");
            else
               $display("end of test: mismatches");
         end
         begin
            wait (idle_cycles >= WATCHDOG);
            $display("timeout");
            $display("end of test: mismatches");
         end
      join_any
      $finish;
   end

endmodule
